// ===== hdl/ckt_pkg.sv =====
package ckt_pkg;

	localparam logic [1:0] MODE_ADD    = 2'd0;
	localparam logic [1:0] MODE_LIST   = 2'd1;
	localparam logic [1:0] MODE_SEARCH = 2'd2;
	localparam logic [1:0] MODE_DELETE = 2'd3;

	localparam logic [2:0] ST_ADDED     = 3'd0;
	localparam logic [2:0] ST_FULL      = 3'd1;
	localparam logic [2:0] ST_FOUND     = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_DELETED   = 3'd4;
	localparam logic [2:0] ST_EMPTY     = 3'd5;
	localparam logic [2:0] ST_ENTRY     = 3'd6;

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [31:0] key;
		logic signed [31:0] value_in;
	} req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [31:0] rec_key;
		logic signed [31:0] rec_value;
		logic               last;
	} rsp_t;

	typedef struct packed {
		logic signed [31:0] key;
		logic signed [31:0] value;
	} rec_t;

	// write: load new record at index count; rotate: ring of count entries
	// moves one step toward cell 0; drop: shift down without wrap
	typedef struct packed {
		logic write;
		logic rotate;
		logic drop;
	} cell_ctl_t;

endpackage

// ===== hdl/ckt_cell.sv =====
module ckt_cell import ckt_pkg::*; #(
	parameter int CNT_W = 7,
	parameter int IDX   = 0
) (
	input  logic             clk,
	input  cell_ctl_t        ctl,
	input  logic [CNT_W-1:0] count,
	input  rec_t             new_rec,
	input  rec_t             next_rec,
	input  rec_t             head_rec,
	output rec_t             rec
);

	localparam logic [CNT_W-1:0] MY_IDX  = CNT_W'(IDX);
	localparam logic [CNT_W-1:0] TAIL_AT = CNT_W'(IDX + 1);

	rec_t rec_q;

	always_ff @(posedge clk) begin
		if (ctl.write) begin
			if (count == MY_IDX) begin
				rec_q <= new_rec;
			end
		end else if (ctl.rotate) begin
			if (count == TAIL_AT) begin
				rec_q <= head_rec;
			end else begin
				rec_q <= next_rec;
			end
		end else if (ctl.drop) begin
			rec_q <= next_rec;
		end
	end

	assign rec = rec_q;

endmodule

// ===== hdl/compacting_key_table.sv =====
// channel   signals                  handshake
// request   start, req (req_t)       taken when start is high and busy is low
// result    done, rsp (rsp_t)        one cycle per result, always taken
//
// add does not set busy; the block can take the next request right after it.
// list, search and delete on a table of n records hold busy while the
// record ring turns once past cell 0, one cell step per cycle.
// list gives one result per cycle during the turn; search and delete give
// theirs at its end. on an empty table no request sets busy.
// arst_n clears the count and control; record cells are not cleared.
module compacting_key_table import ckt_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	output logic done,
	output rsp_t rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
	localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);

	logic             busy_q;
	logic [1:0]       mode_q;
	logic [31:0]      key_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] step_q;
	logic [CNT_W-1:0] n_q;
	logic             hit_q;
	rec_t             hit_rec_q;
	logic             done_q;
	rsp_t             rsp_q;

	cell_ctl_t ctl;
	rec_t      new_rec;
	rec_t      cell_rec [CAPACITY];
	rec_t      head;
	logic      accept;
	logic      match;
	logic      final_step;

	assign accept     = start && !busy_q;
	assign head       = cell_rec[0];
	assign match      = !hit_q && (head.key == key_q);
	assign final_step = (step_q == n_q - ONE);
	assign new_rec    = '{key: req.key, value: req.value_in};

	always_comb begin
		ctl = '0;
		if (accept && req.mode == MODE_ADD && cnt_q != CAP_CNT) begin
			ctl.write = 1'b1;
		end else if (busy_q) begin
			if (mode_q == MODE_DELETE && match) begin
				ctl.drop = 1'b1;
			end else begin
				ctl.rotate = 1'b1;
			end
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		rec_t nxt;
		if (i == CAPACITY - 1) begin : g_end
			assign nxt = cell_rec[0];
		end else begin : g_mid
			assign nxt = cell_rec[i + 1];
		end
		ckt_cell #(.CNT_W(CNT_W), .IDX(i)) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.count    (cnt_q),
			.new_rec  (new_rec),
			.next_rec (nxt),
			.head_rec (head),
			.rec      (cell_rec[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			step_q <= '0;
			n_q    <= '0;
			hit_q  <= 1'b0;
			done_q <= 1'b0;
			mode_q <= MODE_ADD;
		end else begin
			done_q <= 1'b0;
			if (accept) begin
				mode_q <= req.mode;
				step_q <= '0;
				n_q    <= cnt_q;
				hit_q  <= 1'b0;
				if (req.mode == MODE_ADD) begin
					done_q <= 1'b1;
					if (cnt_q != CAP_CNT) begin
						cnt_q <= cnt_q + ONE;
					end
				end else if (cnt_q == '0) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				step_q <= step_q + ONE;
				if (match) begin
					hit_q <= 1'b1;
					if (mode_q == MODE_DELETE) begin
						cnt_q <= cnt_q - ONE;
					end
				end
				if (mode_q == MODE_LIST || final_step) begin
					done_q <= 1'b1;
				end
				if (final_step) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= req.key;
			case (req.mode)
				MODE_ADD: begin
					rsp_q <= '{status: (cnt_q == CAP_CNT) ? ST_FULL : ST_ADDED,
						rec_key: '0, rec_value: '0, last: 1'b1};
				end
				MODE_LIST: begin
					rsp_q <= '{status: ST_EMPTY, rec_key: '0, rec_value: '0, last: 1'b1};
				end
				default: begin
					rsp_q <= '{status: ST_NOT_FOUND, rec_key: '0, rec_value: '0,
						last: 1'b1};
				end
			endcase
		end else if (busy_q) begin
			if (match) begin
				hit_rec_q <= head;
			end
			case (mode_q)
				MODE_LIST: begin
					rsp_q.status    <= ST_ENTRY;
					rsp_q.rec_key   <= head.key;
					rsp_q.rec_value <= head.value;
					rsp_q.last      <= final_step;
				end
				MODE_SEARCH: begin
					rsp_q.last <= 1'b1;
					if (match) begin
						rsp_q.status    <= ST_FOUND;
						rsp_q.rec_key   <= head.key;
						rsp_q.rec_value <= head.value;
					end else if (hit_q) begin
						rsp_q.status    <= ST_FOUND;
						rsp_q.rec_key   <= hit_rec_q.key;
						rsp_q.rec_value <= hit_rec_q.value;
					end else begin
						rsp_q.status    <= ST_NOT_FOUND;
						rsp_q.rec_key   <= '0;
						rsp_q.rec_value <= '0;
					end
				end
				default: begin
					rsp_q.last      <= 1'b1;
					rsp_q.rec_key   <= '0;
					rsp_q.rec_value <= '0;
					rsp_q.status    <= (match || hit_q) ? ST_DELETED : ST_NOT_FOUND;
				end
			endcase
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule
